// ===== hdl/mm_pkg.sv =====
// Shared constants, command/status types and helpers for the matrix multiply core.
package mm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int DIM_W     = 4;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(2 * DEPTH + 1);
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;

  // Configuration port
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  // Controller to datapath
  typedef struct packed {
    logic              abort;
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic              first_k;
    logic              last_k;
    logic              emit;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } mm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } mm_status_t;

  // Map a size register onto the legal range 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

// ===== hdl/mm_datapath.sv =====
// Datapath: operand stores, multiply-accumulate pipeline, scaling and output register.
module mm_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mm_pkg::mm_cmd_t                 cmd_i,
  output mm_pkg::mm_status_t              status_o,
  input  logic [mm_pkg::ELEM_W-1:0]       element_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [mm_pkg::ELEM_W-1:0] product_value_o,
  output logic [mm_pkg::IDX_W-1:0]        result_row_o,
  output logic [mm_pkg::IDX_W-1:0]        result_col_o,
  output logic                            last_result_o
);
  import mm_pkg::*;

  logic [ELEM_W-1:0] mem_a_q [DEPTH];
  logic [ELEM_W-1:0] mem_b_q [DEPTH];

  logic [ELEM_W-1:0]        a_rd_q, b_rd_q;
  logic                     s1_v_q, s1_first_q, s1_last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     s2_v_q, s2_first_q, s2_last_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     done_q;

  logic signed [ELEM_W-1:0] product_q, sat_val;
  logic [IDX_W-1:0]         row_q, col_q;
  logic                     last_q, out_valid_q;
  logic [ACC_W-FRAC_BITS-ELEM_W:0] acc_top;

  // Store elements of A and B as they stream in
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) mem_a_q[cmd_i.wr_addr] <= element_value_i;
    if (cmd_i.wr_b) mem_b_q[cmd_i.wr_addr] <= element_value_i;
  end

  // Read one operand pair per cycle, multiply, accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      a_rd_q <= mem_a_q[cmd_i.rd_a_addr];
      b_rd_q <= mem_b_q[cmd_i.rd_b_addr];
    end
    if (s1_v_q) prod_q <= $signed(a_rd_q) * $signed(b_rd_q);
    if (s2_v_q) acc_q  <= acc_d;
  end

  always_comb begin
    acc_d = (s2_first_q ? ACC_W'(0) : acc_q)
            + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  end

  // Track valid operands through the pipeline; flag the finished dot product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_v_q     <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      done_q     <= 1'b0;
    end else if (cmd_i.abort) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_v_q     <= cmd_i.rd;
      s1_first_q <= cmd_i.first_k;
      s1_last_q  <= cmd_i.last_k;
      s2_v_q     <= s1_v_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      if (s2_v_q && s2_last_q) done_q <= 1'b1;
      else if (cmd_i.emit)     done_q <= 1'b0;
    end
  end

  // Drop the fraction bits (floor) and saturate to 32 bits
  always_comb begin
    acc_top = acc_q[ACC_W-1:FRAC_BITS+ELEM_W-1];
    if ((&acc_top) || !(|acc_top)) begin
      sat_val = acc_q[FRAC_BITS+ELEM_W-1:FRAC_BITS];
    end else begin
      sat_val = {acc_q[ACC_W-1], {(ELEM_W-1){~acc_q[ACC_W-1]}}};
    end
  end

  // Output register: load on emit, hold while stalled
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      product_q <= sat_val;
      row_q     <= cmd_i.row;
      col_q     <= cmd_i.col;
      last_q    <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.acc_done = done_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign product_value_o = product_q;
  assign result_row_o    = row_q;
  assign result_col_o    = col_q;
  assign last_result_o   = last_q;

`ifndef ASSERT_OFF
  a_emit_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!s1_v_q && !s2_v_q))
    else $error("result emitted while products still in flight");

  a_no_issue_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> !done_q)
    else $error("new dot product started before the previous one was emitted");

  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.rd && (cmd_i.wr_a || cmd_i.wr_b)))
    else $error("store written while a dot product is being read");
`endif

endmodule

// ===== hdl/mm_ctrl.sv =====
// Controller: load sequencing, dot product issue and result emission.
module mm_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_i,
  input  logic [mm_pkg::DIM_W-1:0]   nr_i,
  input  logic [mm_pkg::DIM_W-1:0]   nk_i,
  input  logic [mm_pkg::DIM_W-1:0]   nc_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  output mm_pkg::mm_cmd_t            cmd_o,
  input  mm_pkg::mm_status_t         status_i
);
  import mm_pkg::*;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  r_q, r_d, c_q, c_d, k_q, k_d;
  logic [ADDR_W-1:0] rbase_q, rbase_d, kbase_q, kbase_d;

  logic [CNT_W-1:0]  size_a, total, b_off;
  logic [DIM_W-1:0]  nr_m1, nk_m1, nc_m1;
  logic              accept, r_end, c_end, k_end;

  assign size_a = CNT_W'(nr_i) * CNT_W'(nk_i);
  assign total  = size_a + CNT_W'(nk_i) * CNT_W'(nc_i);
  assign b_off  = cnt_q - size_a;
  assign nr_m1  = nr_i - DIM_W'(1);
  assign nk_m1  = nk_i - DIM_W'(1);
  assign nc_m1  = nc_i - DIM_W'(1);
  assign r_end  = DIM_W'(r_q) == nr_m1;
  assign c_end  = DIM_W'(c_q) == nc_m1;
  assign k_end  = DIM_W'(k_q) == nk_m1;

  assign in_stall_o = state_q != S_LOAD;
  assign accept     = in_valid_i && (state_q == S_LOAD);

  // Next-state and command logic
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    rbase_d = rbase_q;
    kbase_d = kbase_q;

    cmd_o           = '0;
    cmd_o.abort     = cfg_wr_i;
    cmd_o.rd_a_addr = rbase_q + ADDR_W'(k_q);
    cmd_o.rd_b_addr = kbase_q + ADDR_W'(c_q);
    cmd_o.first_k   = k_q == '0;
    cmd_o.last_k    = k_end;
    cmd_o.row       = r_q;
    cmd_o.col       = c_q;
    cmd_o.last      = r_end && c_end;
    cmd_o.wr_addr   = (cnt_q < size_a) ? cnt_q[ADDR_W-1:0] : b_off[ADDR_W-1:0];

    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          cmd_o.wr_a = cnt_q < size_a;
          cmd_o.wr_b = !(cnt_q < size_a);
          if (cnt_q == total - CNT_W'(1)) begin
            cnt_d   = '0;
            r_d     = '0;
            c_d     = '0;
            k_d     = '0;
            rbase_d = '0;
            kbase_d = '0;
            state_d = S_ISSUE;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      S_ISSUE: begin
        cmd_o.rd = 1'b1;
        if (k_end) begin
          k_d     = '0;
          kbase_d = '0;
          state_d = S_WAIT;
        end else begin
          k_d     = k_q + IDX_W'(1);
          kbase_d = kbase_q + ADDR_W'(nc_i);
        end
      end
      S_WAIT: begin
        if (status_i.acc_done && status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_ISSUE;
          if (c_end) begin
            c_d = '0;
            if (r_end) begin
              r_d     = '0;
              rbase_d = '0;
              state_d = S_LOAD;
            end else begin
              r_d     = r_q + IDX_W'(1);
              rbase_d = rbase_q + ADDR_W'(nk_i);
            end
          end else begin
            c_d = c_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    // A register write abandons the load or dot product in progress
    if (cfg_wr_i) begin
      state_d    = S_LOAD;
      cnt_d      = '0;
      cmd_o.wr_a = 1'b0;
      cmd_o.wr_b = 1'b0;
      cmd_o.rd   = 1'b0;
      cmd_o.emit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      rbase_q <= '0;
      kbase_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
      rbase_q <= rbase_d;
      kbase_q <= kbase_d;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (cnt_q < total))
    else $error("load count ran past the matrix sizes");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (DIM_W'(k_q) < nk_i))
    else $error("inner index ran past inner_dim");
`endif

endmodule

// ===== hdl/matrix_multiply_core.sv =====
// Top level of the matrix multiply core: configuration registers and unit hookup.
//
// Usage:
//   Program rows_a, inner_dim and cols_b over the APB-style port (byte addresses
//   0, 4, 8; sizes of 0 act as 1, sizes above 8 act as 8). A size register
//   write drops elements already loaded. Then stream rows_a*inner_dim
//   elements of A and inner_dim*cols_b elements of B, row-major, as Q16.16
//   transactions on the input channel, one per cycle. After the last element
//   of B the block stalls its input and returns C row-major, one transaction
//   per entry with its row, column and a last flag on the final entry.
// Datapath:
//   Each result comes from the single multiply-accumulate unit, which reads
//   one operand pair per cycle from the two stores and runs a three-stage
//   read, multiply, accumulate pipeline. The input opens again as soon as
//   the last result sits in the output register.
// Reset and stall:
//   Reset sets all sizes to 8, empties the load and drops any pending result.
//   A stalled result holds in the output register; the next result waits behind it.
module matrix_multiply_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mm_pkg::PADDR_W-1:0]        paddr,
  input  logic [mm_pkg::PDATA_W-1:0]        pwdata,
  output logic [mm_pkg::PDATA_W-1:0]        prdata,
  output logic                              pready,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [mm_pkg::ELEM_W-1:0]  element_value_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mm_pkg::ELEM_W-1:0]  product_value_o,
  output logic [mm_pkg::IDX_W-1:0]          result_row_o,
  output logic [mm_pkg::IDX_W-1:0]          result_col_o,
  output logic                              last_result_o
);
  import mm_pkg::*;

  logic [DIM_W-1:0]     rows_a_q, inner_dim_q, cols_b_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 apb_wr, cfg_wr;
  mm_cmd_t              cmd;
  mm_status_t           status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign apb_wr  = psel && penable && pwrite && pready;

  // Decode register writes; unknown addresses are ignored
  always_comb begin
    unique case (reg_idx) inside
      REG_ROWS_A, REG_INNER_DIM, REG_COLS_B: cfg_wr = apb_wr;
      default:                               cfg_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (apb_wr) begin
      unique case (reg_idx)
        REG_ROWS_A:    rows_a_q    <= pwdata[DIM_W-1:0];
        REG_INNER_DIM: inner_dim_q <= pwdata[DIM_W-1:0];
        REG_COLS_B:    cols_b_q    <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_idx)
      REG_ROWS_A:    prdata = PDATA_W'(rows_a_q);
      REG_INNER_DIM: prdata = PDATA_W'(inner_dim_q);
      REG_COLS_B:    prdata = PDATA_W'(cols_b_q);
      default:       prdata = '0;
    endcase
  end

  mm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_wr),
    .nr_i       (clamp_dim(rows_a_q)),
    .nk_i       (clamp_dim(inner_dim_q)),
    .nc_i       (clamp_dim(cols_b_q)),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  mm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .product_value_o (product_value_o),
    .result_row_o    (result_row_o),
    .result_col_o    (result_col_o),
    .last_result_o   (last_result_o)
  );

endmodule

// ===== test/tb_matrix_multiply_core.sv =====
// Self-checking testbench for matrix_multiply_core: directed corner loads, fixed-size loads, then random loads.
`timescale 1ns / 1ps
module tb_matrix_multiply_core;
  import mm_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int ITEM_TARGET     = 470;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int QUIET_LIMIT     = 3000;

  // Address slot past the last size register; writes to it are dropped
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [79:0] SAT_MAX = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] SAT_MIN = -80'sh8000_0000;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } product_t;

  typedef enum logic {ROW_WRITE, ROW_ELEMENT} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [31:0]          data;
    logic                 typed;
    logic [ELEM_W-1:0]    value;
  } stim_row_t;

  localparam int NUM_DIRECTED = 33;

  // Directed loads; typed results are single 1x1 or 1xKx1 entries at row 0, col 0
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // 1x1x1: saturation and rounding
    '{ROW_WRITE,   REG_ROWS_A,    32'h0000_0001, 1'b0, 32'h0000_0000},
    '{ROW_WRITE,   REG_INNER_DIM, 32'h0000_0001, 1'b0, 32'h0000_0000},
    '{ROW_WRITE,   REG_COLS_B,    32'h0000_0001, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{ROW_ELEMENT, REG_UNUSED,    32'h8000_0000, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
    '{ROW_ELEMENT, REG_UNUSED,    32'h8000_0000, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h0001_0000, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'hFFFF_0000, 1'b1, 32'hFFFF_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h0000_0001, 1'b1, 32'hFFFF_FFFF},
    // zero sizes act as one; upper data bits are dropped
    '{ROW_WRITE,   REG_ROWS_A,    32'hFFFF_FFF0, 1'b0, 32'h0000_0000},
    '{ROW_WRITE,   REG_INNER_DIM, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{ROW_WRITE,   REG_COLS_B,    32'h1234_5670, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h0002_0000, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h0003_0000, 1'b1, 32'h0006_0000},
    // 1x2x1: intermediate products cancel; out-of-range address mid-load
    '{ROW_WRITE,   REG_INNER_DIM, 32'h0000_0002, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{ROW_WRITE,   REG_UNUSED,    32'h0000_0005, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h8000_0001, 1'b1, 32'h0000_0000},
    // partial load dropped by a size write, then a 1x2x2 load
    '{ROW_ELEMENT, REG_UNUSED,    32'h0001_8000, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'hFFFE_0000, 1'b0, 32'h0000_0000},
    '{ROW_WRITE,   REG_COLS_B,    32'h0000_0002, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h0001_8000, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'hFFFE_0000, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h0001_0000, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h8000_0000, 1'b0, 32'h0000_0000},
    '{ROW_ELEMENT, REG_UNUSED,    32'h0000_4000, 1'b0, 32'h0000_0000}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [ELEM_W-1:0] element_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [ELEM_W-1:0] product_value_o;
  logic [IDX_W-1:0]         result_row_o;
  logic [IDX_W-1:0]         result_col_o;
  logic                     last_result_o;

  // Predictor state: size codes as written, both operand stores, load position
  logic [DIM_W-1:0]  rows_code  = DIM_RESET;
  logic [DIM_W-1:0]  inner_code = DIM_RESET;
  logic [DIM_W-1:0]  cols_code  = DIM_RESET;
  logic [ELEM_W-1:0] a_store [DEPTH];
  logic [ELEM_W-1:0] b_store [DEPTH];
  int unsigned       loaded_count = 0;

  product_t    fresh_products[$];
  product_t    expected_products[$];
  int unsigned items_sent    = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  logic        hold_off_req  = 1'b0;

  matrix_multiply_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .product_value_o(product_value_o),
    .result_row_o   (result_row_o),
    .result_col_o   (result_col_o),
    .last_result_o  (last_result_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Effective size of a size code
  function automatic int unsigned used_dim(input logic [DIM_W-1:0] code);
    if (code == '0) return 1;
    if (code > MAX_DIM) return MAX_DIM;
    return code;
  endfunction

  function automatic int unsigned load_length();
    return used_dim(rows_code) * used_dim(inner_code)
         + used_dim(inner_code) * used_dim(cols_code);
  endfunction

  // Store one element; on the last element of B, compute all of C into fresh_products
  function automatic void multiply_step(input logic [ELEM_W-1:0] elem);
    int unsigned       nr;
    int unsigned       nk;
    int unsigned       nc;
    int unsigned       size_a;
    int unsigned       total;
    logic signed [79:0] acc;
    logic signed [79:0] scaled;
    product_t          entry;
    nr = used_dim(rows_code);
    nk = used_dim(inner_code);
    nc = used_dim(cols_code);
    size_a = nr * nk;
    total = size_a + nk * nc;
    fresh_products.delete();
    if (loaded_count >= total) loaded_count = 0;
    if (loaded_count < size_a) a_store[loaded_count] = elem;
    else b_store[loaded_count - size_a] = elem;
    loaded_count++;
    if (loaded_count < total) return;
    loaded_count = 0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        acc = '0;
        for (int k = 0; k < nk; k++)
          acc = acc + $signed(a_store[r * nk + k]) * $signed(b_store[k * nc + c]);
        scaled = acc >>> FRAC_BITS;
        if (scaled > SAT_MAX) entry.value = 32'h7FFF_FFFF;
        else if (scaled < SAT_MIN) entry.value = 32'h8000_0000;
        else entry.value = scaled[ELEM_W-1:0];
        entry.row = IDX_W'(r);
        entry.col = IDX_W'(c);
        entry.last = (r == nr - 1) && (c == nc - 1);
        fresh_products = {fresh_products, entry};
      end
    end
  endfunction

  // Mostly small Q16.16 values, some full-range words, a few extremes
  function automatic logic [ELEM_W-1:0] random_element();
    case ($urandom_range(0, 9)) inside
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0001_0000;
          default: return 32'h0000_0000;
        endcase
      end
      [1:3]: return $urandom();
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  // Sender gap: mostly none, some short, a few long
  function automatic int unsigned next_gap();
    case ($urandom_range(0, 49)) inside
      0: return $urandom_range(15, 40);
      [1:4]: return $urandom_range(4, 10);
      [5:19]: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  // Size code: mostly 1..4, sometimes larger, zero or out of range
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19)) inside
      [0:1]: return '0;
      2: return DIM_W'($urandom_range(9, 15));
      [3:4]: return DIM_W'($urandom_range(5, 8));
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [31:0] with_noise(input logic [DIM_W-1:0] code);
    return ($urandom() & ~32'hF) | 32'(code);
  endfunction

  // One APB transfer: setup phase, access phase until pready, then idle with psel low
  task automatic apb_transfer(input logic write, input logic [REG_IDX_W-1:0] idx,
                              input logic [31:0] wdata, output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_check(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] wanted);
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b0, idx, '0, rd);
    if (rd[DIM_W-1:0] !== wanted) begin
      mismatches++;
      $display("%0t: register %0d read back: expected %h, got %h",
               $time, idx, wanted, rd[DIM_W-1:0]);
    end
  endtask

  // Write a register, mirror it in the predictor and read it back unless it is the unused slot
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    logic [PDATA_W-1:0] unused_rd;
    apb_transfer(1'b1, idx, data, unused_rd);
    case (idx)
      REG_ROWS_A:    rows_code  = data[DIM_W-1:0];
      REG_INNER_DIM: inner_code = data[DIM_W-1:0];
      REG_COLS_B:    cols_code  = data[DIM_W-1:0];
      default: begin
      end
    endcase
    if (idx != REG_UNUSED) begin
      loaded_count = 0;
      read_check(idx, data[DIM_W-1:0]);
    end
  endtask

  // Drop valid, wait for all pending results, then let the pipeline drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                           input logic [DIM_W-1:0] c);
    settle();
    write_reg(REG_ROWS_A, with_noise(r));
    write_reg(REG_INNER_DIM, with_noise(k));
    write_reg(REG_COLS_B, with_noise(c));
  endtask

  // Offer one element, hold it until accepted, then queue what it produces
  task automatic send_element(input logic [ELEM_W-1:0] elem, input int unsigned gap,
                              input logic typed, input logic [ELEM_W-1:0] typed_value);
    product_t typed_product;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= elem;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    multiply_step(elem);
    if (typed && fresh_products.size() != 0) begin
      typed_product = '{value: typed_value, row: '0, col: '0, last: 1'b1};
      expected_products = {expected_products, typed_product};
    end else begin
      foreach (fresh_products[i]) expected_products = {expected_products, fresh_products[i]};
    end
  endtask

  task automatic send_load(input int unsigned count, input logic gapless);
    for (int i = 0; i < count; i++)
      send_element(random_element(), gapless ? 0 : next_gap(), 1'b0, '0);
  endtask

  // Receiver stall: random runs, plus one long hold-off on request
  initial begin
    int unsigned run;
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        case ($urandom_range(0, 19)) inside
          [0:1]: begin
            out_stall_i <= 1'b0;
            run = $urandom_range(50, 100);
          end
          [2:9]: begin
            out_stall_i <= 1'b0;
            run = $urandom_range(1, 20);
          end
          [18:19]: begin
            out_stall_i <= 1'b1;
            run = $urandom_range(10, 40);
          end
          default: begin
            out_stall_i <= 1'b1;
            run = $urandom_range(1, 3);
          end
        endcase
        repeat (run) begin
          @(posedge clk_i);
          if (hold_off_req) break;
        end
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_monitor
    product_t seen;
    product_t wanted;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{value: product_value_o, row: result_row_o, col: result_col_o,
               last: last_result_o};
      if (expected_products.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got %h (%0d,%0d) last %0b",
                 $time, seen.value, seen.row, seen.col, seen.last);
      end else begin
        wanted = expected_products.pop_front();
        if (seen !== wanted) begin
          mismatches++;
          $display("%0t: expected %h (%0d,%0d) last %0b, got %h (%0d,%0d) last %0b",
                   $time, wanted.value, wanted.row, wanted.col, wanted.last,
                   seen.value, seen.row, seen.col, seen.last);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int unsigned total;
    int unsigned split;
    logic        abandoned;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid_i      <= 1'b0;
    element_value_i <= '0;
    rst_ni          <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sizes after reset
    read_check(REG_ROWS_A, DIM_RESET);
    read_check(REG_INNER_DIM, DIM_RESET);
    read_check(REG_COLS_B, DIM_RESET);

    // Walk the directed rows
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
        settle();
        write_reg(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].data);
      end else begin
        send_element(DIRECTED_ROWS[i].data, next_gap(), DIRECTED_ROWS[i].typed,
                     DIRECTED_ROWS[i].value);
      end
    end

    // Back-to-back loads against a long receiver hold-off
    configure(4'd4, 4'd4, 4'd4);
    hold_off_req = 1'b1;
    repeat (3) send_load(load_length(), 1'b1);

    // Largest sizes, widest result, longest dot product
    configure(4'd8, 4'd15, 4'd8);
    send_load(load_length(), 1'b0);
    configure(4'd8, 4'd1, 4'd8);
    send_load(load_length(), 1'b0);
    configure(4'd1, 4'd8, 4'd1);
    send_load(load_length(), 1'b0);

    // Random sizes and loads, with dropped and interrupted loads mixed in
    while (items_sent < ITEM_TARGET) begin
      configure(pick_dim(), pick_dim(), pick_dim());
      total = load_length();
      abandoned = 1'b0;
      repeat ($urandom_range(1, 3)) begin
        if (!abandoned) begin
          case ($urandom_range(0, 9))
            0: begin
              if (total > 1) begin
                send_load($urandom_range(1, total - 1), 1'b0);
                abandoned = 1'b1;
              end else begin
                send_load(total, 1'b0);
              end
            end
            1: begin
              if (total > 1) begin
                split = $urandom_range(1, total - 1);
                send_load(split, 1'b0);
                settle();
                write_reg(REG_UNUSED, $urandom());
                send_load(total - split, 1'b0);
              end else begin
                send_load(total, 1'b0);
              end
            end
            default: send_load(total, $urandom_range(0, 3) == 0);
          endcase
        end
      end
    end

    settle();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
